// ===== sv/tcse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcse_pkg
// Shared types and constants of the TCP connection state engine: request and
// result layouts, slot entry and adder layouts, flag codes, states and the flag decoder.
// ============================================================================
package tcse_pkg;

    // TCP flag bytes handled by the engine
    localparam logic [7:0] FLAG_FIN         = 8'h01;
    localparam logic [7:0] FLAG_SYN         = 8'h02;
    localparam logic [7:0] FLAG_RST         = 8'h04;
    localparam logic [7:0] FLAG_ACK         = 8'h10;
    localparam logic [7:0] FLAG_FIN_ACK     = 8'h11;
    localparam logic [7:0] FLAG_SYN_ACK     = 8'h12;
    localparam logic [7:0] FLAG_RST_ACK     = 8'h14;
    localparam logic [7:0] FLAG_PSH_ACK     = 8'h18;
    localparam logic [7:0] FLAG_CWR_PSH_ACK = 8'h98;
    localparam logic [7:0] FLAG_NONE        = 8'h00;

    // Shortest segment that carries a full TCP header
    localparam logic [15:0] MIN_SEG_LEN = 16'd20;

    // Request codes
    localparam logic OP_SEGMENT    = 1'b0;
    localparam logic OP_HOST_WRITE = 1'b1;

    // Connection state of a slot
    typedef enum logic [2:0] {
        ST_CLOSED    = 3'd0,
        ST_SYN_SENT  = 3'd1,
        ST_SYN_RCVD  = 3'd2,
        ST_ESTAB     = 3'd3,
        ST_FIN_WAIT1 = 3'd4,
        ST_FIN_WAIT2 = 3'd5
    } conn_state_t;

    // Segment class after flag decode
    typedef enum logic [2:0] {
        CLS_SYN,
        CLS_SYN_ACK,
        CLS_ACK,
        CLS_FIN,
        CLS_RST,
        CLS_OTHER
    } seg_class_t;

    // Sequencer steps
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_PAY,
        SEQ_CMP,
        SEQ_ADD1,
        SEQ_ADD2,
        SEQ_DONE,
        SEQ_OUT
    } seq_state_t;

    // Input request
    typedef struct packed {
        logic        opcode;
        logic [7:0]  tcp_flags;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] segment_len;
        logic [3:0]  header_words;
        logic        checksum_ok;
        logic        lookup_hit;
        logic [3:0]  slot_index;
        logic [31:0] initial_send_seq;
        logic        buffer_room;
        logic [2:0]  host_state;
    } tcse_req_t;

    // Result
    typedef struct packed {
        logic        reply_valid;
        logic [7:0]  reply_flags;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic        expire_valid;
        logic [31:0] expire_upto;
        logic        release_queue;
        logic        payload_accept;
        logic [15:0] payload_bytes;
        logic [2:0]  slot_state_out;
    } tcse_rsp_t;

    // One slot of the connection table
    typedef struct packed {
        conn_state_t state;
        logic [31:0] send_seq;
        logic [31:0] recv_ack;
    } slot_entry_t;

    // Operands of the shared adder
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } alu_req_t;

    // Adder result and flags
    typedef struct packed {
        logic [31:0] sum;
        logic        carry;
        logic        zero;
    } alu_rsp_t;

    // Map a flag byte onto the handled segment classes
    function automatic seg_class_t decode_class(input logic [7:0] flags);
        seg_class_t cls;
        unique case (flags) inside
            FLAG_SYN:                                   cls = CLS_SYN;
            FLAG_SYN_ACK:                               cls = CLS_SYN_ACK;
            FLAG_ACK, FLAG_PSH_ACK, FLAG_CWR_PSH_ACK:   cls = CLS_ACK;
            FLAG_FIN, FLAG_FIN_ACK:                     cls = CLS_FIN;
            FLAG_RST, FLAG_RST_ACK:                     cls = CLS_RST;
            default:                                    cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

endpackage

// ===== sv/tcse_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcse_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module tcse_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/tcse_alu.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcse_alu
// Shared 32-bit add/subtract unit with carry and zero flags, used by the
// sequencer for payload length, sequence compares and sequence increments.
// ============================================================================
module tcse_alu (
    input  tcse_pkg::alu_req_t req,
    output tcse_pkg::alu_rsp_t rsp
);

    logic [31:0] b_op;
    logic [32:0] total;

    // Subtract as a plus inverted b plus one
    always_comb begin
        b_op  = req.sub ? ~req.b : req.b;
        total = {1'b0, req.a} + {1'b0, b_op} + {32'd0, req.sub};
    end

    assign rsp.sum   = total[31:0];
    assign rsp.carry = total[32];
    assign rsp.zero  = (total[31:0] == 32'd0);

endmodule

// ===== sv/tcp_connection_state_engine.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tcp_connection_state_engine
// Per-segment TCP connection state update over a table of connection slots.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data take one request: a received, already checked and
//   looked-up segment header, or a host write of a slot's state and send
//   sequence. m_valid/m_ready/m_data return exactly one result per request:
//   reply segment fields, send queue expire, queue release, payload accept
//   and the slot's new state.
//   One request is worked on at a time. After acceptance the slot entry is
//   read from the table RAM, then one shared adder runs four steps (payload
//   length, sequence compare, two increments), and the entry is written
//   back. The result is held in the output register; s_ready returns the
//   cycle after the result is taken.
//   A stalled receiver holds the result in the output register and the block
//   takes no further request until it is taken.
//   Reset clears the sequencer and the per-slot valid bits, so every slot
//   reads as closed with zero sequence numbers; no clearing pass is needed.
// ============================================================================
module tcp_connection_state_engine #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcse_pkg::tcse_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcse_pkg::tcse_rsp_t m_data
);

    localparam int ADDR_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_W = $bits(tcse_pkg::slot_entry_t);

    tcse_pkg::seq_state_t  state_reg, state_next;
    tcse_pkg::tcse_req_t   req_reg;
    tcse_pkg::slot_entry_t ent_reg;
    tcse_pkg::slot_entry_t ent_next;
    tcse_pkg::tcse_rsp_t   rsp_reg, rsp_next;
    tcse_pkg::seg_class_t  cls_reg;
    tcse_pkg::alu_req_t    alu_req;
    tcse_pkg::alu_rsp_t    alu_rsp;
    logic [15:0]           pay_reg;
    logic                  match_reg;
    logic [31:0]           sum1_reg;
    logic [31:0]           sum2_reg;
    logic                  hit_reg;
    logic                  range_reg;
    logic [NUM_SLOTS-1:0]  slot_vld_reg;
    logic                  accept;
    logic                  good_seg;
    logic                  ram_wr;
    logic [ADDR_W+3:0]     s_addr_ext;
    logic [ADDR_W+3:0]     r_addr_ext;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  in_range;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == tcse_pkg::SEQ_IDLE);
    assign m_valid    = (state_reg == tcse_pkg::SEQ_OUT);
    assign m_data     = rsp_reg;
    assign s_addr_ext = {{ADDR_W{1'b0}}, s_data.slot_index};
    assign r_addr_ext = {{ADDR_W{1'b0}}, req_reg.slot_index};
    assign rd_addr    = s_addr_ext[ADDR_W-1:0];
    assign addr       = r_addr_ext[ADDR_W-1:0];
    assign in_range   = ({28'd0, s_data.slot_index} < 32'(NUM_SLOTS));
    assign good_seg   = (req_reg.segment_len >= tcse_pkg::MIN_SEG_LEN)
                        && req_reg.checksum_ok;

    // Slot table
    tcse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (addr),
        .wr_data (ent_next),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared adder
    tcse_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcse_pkg::SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through the steps of one request
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcse_pkg::SEQ_IDLE: if (accept) state_next = tcse_pkg::SEQ_PAY;
            tcse_pkg::SEQ_PAY:  state_next = tcse_pkg::SEQ_CMP;
            tcse_pkg::SEQ_CMP:  state_next = tcse_pkg::SEQ_ADD1;
            tcse_pkg::SEQ_ADD1: state_next = tcse_pkg::SEQ_ADD2;
            tcse_pkg::SEQ_ADD2: state_next = tcse_pkg::SEQ_DONE;
            tcse_pkg::SEQ_DONE: state_next = tcse_pkg::SEQ_OUT;
            tcse_pkg::SEQ_OUT:  if (m_ready) state_next = tcse_pkg::SEQ_IDLE;
            default:            state_next = tcse_pkg::SEQ_IDLE;
        endcase
    end

    // Select adder operands for the current step
    always_comb begin
        alu_req.a   = req_reg.seq_num;
        alu_req.b   = 32'd1;
        alu_req.sub = 1'b0;
        case (state_reg)
            tcse_pkg::SEQ_PAY: begin
                alu_req.a   = {16'd0, req_reg.segment_len};
                alu_req.b   = {26'd0, req_reg.header_words, 2'b00};
                alu_req.sub = 1'b1;
            end
            tcse_pkg::SEQ_CMP: begin
                alu_req.sub = 1'b1;
                if (cls_reg == tcse_pkg::CLS_ACK) begin
                    alu_req.a = req_reg.seq_num;
                    alu_req.b = ent_reg.recv_ack;
                end else begin
                    alu_req.a = req_reg.ack_num;
                    alu_req.b = ent_reg.send_seq;
                end
            end
            tcse_pkg::SEQ_ADD1: begin
                if (!hit_reg) begin
                    alu_req.a = req_reg.ack_num;
                end else if (cls_reg == tcse_pkg::CLS_ACK) begin
                    alu_req.a = ent_reg.recv_ack;
                    alu_req.b = {16'd0, pay_reg};
                end else if (cls_reg == tcse_pkg::CLS_FIN) begin
                    alu_req.a = ent_reg.recv_ack;
                end else begin
                    alu_req.a = req_reg.seq_num;
                end
            end
            tcse_pkg::SEQ_ADD2: begin
                if (!hit_reg) begin
                    alu_req.a = req_reg.seq_num;
                end else if (cls_reg == tcse_pkg::CLS_FIN) begin
                    alu_req.a = ent_reg.send_seq;
                end else begin
                    alu_req.a = req_reg.initial_send_seq;
                end
            end
            default: begin
                alu_req.sub = 1'b0;
            end
        endcase
    end

    // Hold the request and the step results
    always_ff @(posedge aclk) begin
        case (state_reg)
            tcse_pkg::SEQ_IDLE: begin
                if (accept) begin
                    req_reg   <= s_data;
                    cls_reg   <= tcse_pkg::decode_class(s_data.tcp_flags);
                    range_reg <= in_range;
                    hit_reg   <= s_data.lookup_hit && in_range;
                end
            end
            tcse_pkg::SEQ_PAY: begin
                pay_reg <= alu_rsp.carry ? alu_rsp.sum[15:0] : 16'd0;
                ent_reg <= slot_vld_reg[addr] ? tcse_pkg::slot_entry_t'(rd_data)
                                              : '0;
            end
            tcse_pkg::SEQ_CMP:  match_reg <= alu_rsp.zero;
            tcse_pkg::SEQ_ADD1: sum1_reg  <= alu_rsp.sum;
            tcse_pkg::SEQ_ADD2: sum2_reg  <= alu_rsp.sum;
            tcse_pkg::SEQ_DONE: rsp_reg   <= rsp_next;
            default: begin
            end
        endcase
    end

    // Slot valid bits: an unwritten slot reads as closed with zero sequences
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else if (ram_wr) begin
            slot_vld_reg[addr] <= 1'b1;
        end
    end

    // Form the result and the updated slot entry
    always_comb begin
        rsp_next = '0;
        ent_next = ent_reg;
        ram_wr   = 1'b0;
        if (state_reg == tcse_pkg::SEQ_DONE) begin
            if (req_reg.opcode == tcse_pkg::OP_HOST_WRITE) begin
                if (range_reg) begin
                    ent_next.state    = (req_reg.host_state > 3'(tcse_pkg::ST_FIN_WAIT2))
                                        ? tcse_pkg::ST_CLOSED
                                        : tcse_pkg::conn_state_t'(req_reg.host_state);
                    ent_next.send_seq = req_reg.seq_num;
                    ram_wr            = 1'b1;
                    rsp_next.slot_state_out = ent_next.state;
                end
            end else if (good_seg) begin
                rsp_next.payload_bytes = pay_reg;
                case (cls_reg)
                    tcse_pkg::CLS_SYN: begin
                        rsp_next.reply_valid = 1'b1;
                        if (!hit_reg) begin
                            rsp_next.reply_flags = tcse_pkg::FLAG_RST_ACK;
                            rsp_next.reply_seq   = sum1_reg;
                            rsp_next.reply_ack   = sum2_reg;
                        end else begin
                            ent_next.state       = tcse_pkg::ST_SYN_RCVD;
                            ent_next.recv_ack    = sum1_reg;
                            ent_next.send_seq    = sum2_reg;
                            rsp_next.reply_flags = tcse_pkg::FLAG_SYN_ACK;
                            rsp_next.reply_seq   = req_reg.initial_send_seq;
                            rsp_next.reply_ack   = sum1_reg;
                            ram_wr               = 1'b1;
                        end
                    end
                    tcse_pkg::CLS_SYN_ACK: begin
                        if (!hit_reg) begin
                            rsp_next.reply_valid = 1'b1;
                            rsp_next.reply_flags = tcse_pkg::FLAG_RST_ACK;
                            rsp_next.reply_seq   = sum1_reg;
                            rsp_next.reply_ack   = sum2_reg;
                        end else if (match_reg) begin
                            if (ent_reg.state == tcse_pkg::ST_SYN_SENT) begin
                                ent_next.state = tcse_pkg::ST_ESTAB;
                            end
                            ent_next.recv_ack    = sum1_reg;
                            rsp_next.reply_valid = 1'b1;
                            rsp_next.reply_flags = tcse_pkg::FLAG_ACK;
                            rsp_next.reply_seq   = ent_reg.send_seq;
                            rsp_next.reply_ack   = sum1_reg;
                            ram_wr               = 1'b1;
                        end
                    end
                    tcse_pkg::CLS_ACK: begin
                        if (!hit_reg) begin
                            rsp_next.reply_valid = 1'b1;
                            rsp_next.reply_flags = tcse_pkg::FLAG_RST_ACK;
                            rsp_next.reply_seq   = req_reg.ack_num;
                            rsp_next.reply_ack   = req_reg.seq_num;
                        end else begin
                            rsp_next.expire_valid = 1'b1;
                            rsp_next.expire_upto  = req_reg.ack_num;
                            if (!match_reg) begin
                                rsp_next.reply_valid = 1'b1;
                                rsp_next.reply_flags = tcse_pkg::FLAG_ACK;
                                rsp_next.reply_seq   = ent_reg.send_seq;
                                rsp_next.reply_ack   = ent_reg.recv_ack;
                            end else if (ent_reg.state == tcse_pkg::ST_SYN_RCVD) begin
                                ent_next.state = tcse_pkg::ST_ESTAB;
                                ram_wr         = 1'b1;
                            end else if (ent_reg.state == tcse_pkg::ST_FIN_WAIT2) begin
                                rsp_next.release_queue = 1'b1;
                                ent_next.state         = tcse_pkg::ST_CLOSED;
                                ram_wr                 = 1'b1;
                            end else if (ent_reg.state == tcse_pkg::ST_ESTAB
                                         && pay_reg != 16'd0 && req_reg.buffer_room) begin
                                rsp_next.payload_accept = 1'b1;
                                ent_next.recv_ack       = sum1_reg;
                                rsp_next.reply_valid    = 1'b1;
                                rsp_next.reply_flags    = tcse_pkg::FLAG_ACK;
                                rsp_next.reply_seq      = ent_reg.send_seq;
                                rsp_next.reply_ack      = sum1_reg;
                                ram_wr                  = 1'b1;
                            end
                        end
                    end
                    tcse_pkg::CLS_FIN: begin
                        if (!hit_reg) begin
                            rsp_next.reply_valid = 1'b1;
                            rsp_next.reply_flags = tcse_pkg::FLAG_RST_ACK;
                            rsp_next.reply_seq   = sum1_reg;
                            rsp_next.reply_ack   = sum2_reg;
                        end else begin
                            rsp_next.expire_valid = 1'b1;
                            rsp_next.expire_upto  = req_reg.ack_num;
                            if (match_reg) begin
                                ent_next.recv_ack = sum1_reg;
                                ram_wr            = 1'b1;
                                if (ent_reg.state == tcse_pkg::ST_SYN_RCVD
                                    || ent_reg.state == tcse_pkg::ST_ESTAB) begin
                                    rsp_next.reply_valid = 1'b1;
                                    rsp_next.reply_flags = tcse_pkg::FLAG_FIN_ACK;
                                    rsp_next.reply_seq   = ent_reg.send_seq;
                                    rsp_next.reply_ack   = sum1_reg;
                                    ent_next.send_seq    = sum2_reg;
                                    ent_next.state       = tcse_pkg::ST_FIN_WAIT2;
                                end else if (ent_reg.state == tcse_pkg::ST_FIN_WAIT1) begin
                                    rsp_next.reply_valid   = 1'b1;
                                    rsp_next.reply_flags   = tcse_pkg::FLAG_ACK;
                                    rsp_next.reply_seq     = ent_reg.send_seq;
                                    rsp_next.reply_ack     = sum1_reg;
                                    rsp_next.release_queue = 1'b1;
                                    ent_next.state         = tcse_pkg::ST_CLOSED;
                                end
                            end
                        end
                    end
                    tcse_pkg::CLS_RST: begin
                        if (hit_reg) begin
                            ent_next.state         = tcse_pkg::ST_CLOSED;
                            rsp_next.release_queue = 1'b1;
                            ram_wr                 = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (hit_reg) begin
                    rsp_next.slot_state_out = ent_next.state;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // Request side and result side are never open together
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while a result is pending");

    // The slot table is written only when the result is formed
    a_write_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr |-> (state_reg == tcse_pkg::SEQ_DONE))
        else $error("slot table written outside the write-back step");

    // An accepted request starts with the payload step, which latches the slot entry
    a_accept_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == tcse_pkg::SEQ_PAY))
        else $error("accepted request did not start the sequence");

    // A reply carries flags exactly when it is flagged valid
    a_reply_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.reply_valid == (m_data.reply_flags != tcse_pkg::FLAG_NONE)))
        else $error("reply flags disagree with reply valid");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the TCP connection state engine. A short table of
// hand-picked segments and host writes comes first, then randomised traffic
// built mostly from well-formed connection sequences. Every accepted request
// is run through a local copy of the slot table to work out its result, and
// every result leaving the block is compared field by field, in order.
// ============================================================================
module tb;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 1200;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_PERIODIC,
        RX_SPARSE
    } rx_pattern_t;

    // One line of the directed table; live flags pull seq/ack from the slot copy
    typedef struct {
        tcse_pkg::tcse_req_t req;
        bit                  seq_live;
        bit                  ack_live;
        bit                  typed;
        tcse_pkg::tcse_rsp_t rsp;
    } stim_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    tcse_pkg::tcse_req_t s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    tcse_pkg::tcse_rsp_t m_data;

    // Local copy of the connection table
    tcse_pkg::conn_state_t slot_state    [SLOTS];
    logic [31:0]           slot_send_seq [SLOTS];
    logic [31:0]           slot_recv_ack [SLOTS];

    tcse_pkg::tcse_rsp_t   segment_outcomes [$];
    stim_row_t             stimulus_rows    [$];

    int          mismatch_count = 0;
    int          results_seen   = 0;
    int          burst_left     = 0;
    int          long_hold_left = 0;
    bit          long_hold_done = 1'b0;
    rx_pattern_t rx_mode        = RX_ALWAYS;
    int          rx_phase       = 0;

    tcp_connection_state_engine #(
        .NUM_SLOTS (SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // Give up after a generous bound
    initial begin
        #2_000_000;
        $display("** tcp_connection_state_engine: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH @%0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    function automatic tcse_pkg::tcse_rsp_t with_reply(input tcse_pkg::tcse_rsp_t o,
                                                       input logic [7:0] flags,
                                                       input logic [31:0] seq,
                                                       input logic [31:0] ack);
        o.reply_valid = 1'b1;
        o.reply_flags = flags;
        o.reply_seq   = seq;
        o.reply_ack   = ack;
        return o;
    endfunction

    // Work out one result and advance the slot copy
    function automatic tcse_pkg::tcse_rsp_t compute_segment_outcome(
        input tcse_pkg::tcse_req_t r);
        tcse_pkg::tcse_rsp_t o;
        logic [15:0]         hdr_bytes;
        logic [15:0]         payload;
        logic                hit;
        int                  s;
        o   = '0;
        s   = int'(r.slot_index);
        hit = r.lookup_hit;

        // Host write: overwrite state and send sequence, keep recv_ack
        if (r.opcode == tcse_pkg::OP_HOST_WRITE) begin
            slot_state[s]    = (r.host_state > tcse_pkg::ST_FIN_WAIT2)
                               ? tcse_pkg::ST_CLOSED
                               : tcse_pkg::conn_state_t'(r.host_state);
            slot_send_seq[s] = r.seq_num;
            o.slot_state_out = slot_state[s];
            return o;
        end

        // Drop short or corrupt segments silently
        if (r.segment_len < tcse_pkg::MIN_SEG_LEN || !r.checksum_ok)
            return o;

        hdr_bytes       = {10'd0, r.header_words, 2'b00};
        payload         = (r.segment_len > hdr_bytes) ? r.segment_len - hdr_bytes : 16'd0;
        o.payload_bytes = payload;

        case (r.tcp_flags)
            tcse_pkg::FLAG_SYN: begin
                if (!hit) begin
                    o = with_reply(o, tcse_pkg::FLAG_RST_ACK, r.ack_num + 32'd1,
                                   r.seq_num + 32'd1);
                end else begin
                    slot_state[s]    = tcse_pkg::ST_SYN_RCVD;
                    slot_recv_ack[s] = r.seq_num + 32'd1;
                    o = with_reply(o, tcse_pkg::FLAG_SYN_ACK, r.initial_send_seq,
                                   slot_recv_ack[s]);
                    slot_send_seq[s] = r.initial_send_seq + 32'd1;
                end
            end
            tcse_pkg::FLAG_SYN_ACK: begin
                if (!hit) begin
                    o = with_reply(o, tcse_pkg::FLAG_RST_ACK, r.ack_num + 32'd1,
                                   r.seq_num + 32'd1);
                end else if (r.ack_num == slot_send_seq[s]) begin
                    if (slot_state[s] == tcse_pkg::ST_SYN_SENT)
                        slot_state[s] = tcse_pkg::ST_ESTAB;
                    slot_recv_ack[s] = r.seq_num + 32'd1;
                    o = with_reply(o, tcse_pkg::FLAG_ACK, slot_send_seq[s],
                                   slot_recv_ack[s]);
                end
            end
            tcse_pkg::FLAG_ACK, tcse_pkg::FLAG_PSH_ACK, tcse_pkg::FLAG_CWR_PSH_ACK: begin
                if (!hit) begin
                    o = with_reply(o, tcse_pkg::FLAG_RST_ACK, r.ack_num, r.seq_num);
                end else begin
                    o.expire_valid = 1'b1;
                    o.expire_upto  = r.ack_num;
                    if (r.seq_num != slot_recv_ack[s]) begin
                        // Out of order: re-acknowledge what we hold
                        o = with_reply(o, tcse_pkg::FLAG_ACK, slot_send_seq[s],
                                       slot_recv_ack[s]);
                    end else if (slot_state[s] == tcse_pkg::ST_SYN_RCVD) begin
                        slot_state[s] = tcse_pkg::ST_ESTAB;
                    end else if (slot_state[s] == tcse_pkg::ST_FIN_WAIT2) begin
                        o.release_queue = 1'b1;
                        slot_state[s]   = tcse_pkg::ST_CLOSED;
                    end else if (slot_state[s] == tcse_pkg::ST_ESTAB && payload != 16'd0
                                 && r.buffer_room) begin
                        o.payload_accept = 1'b1;
                        slot_recv_ack[s] = slot_recv_ack[s] + {16'd0, payload};
                        o = with_reply(o, tcse_pkg::FLAG_ACK, slot_send_seq[s],
                                       slot_recv_ack[s]);
                    end
                end
            end
            tcse_pkg::FLAG_FIN, tcse_pkg::FLAG_FIN_ACK: begin
                if (!hit) begin
                    o = with_reply(o, tcse_pkg::FLAG_RST_ACK, r.ack_num + 32'd1,
                                   r.seq_num + 32'd1);
                end else begin
                    o.expire_valid = 1'b1;
                    o.expire_upto  = r.ack_num;
                    if (r.ack_num == slot_send_seq[s]) begin
                        slot_recv_ack[s] = slot_recv_ack[s] + 32'd1;
                        if (slot_state[s] == tcse_pkg::ST_SYN_RCVD
                            || slot_state[s] == tcse_pkg::ST_ESTAB) begin
                            o = with_reply(o, tcse_pkg::FLAG_FIN_ACK, slot_send_seq[s],
                                           slot_recv_ack[s]);
                            slot_send_seq[s] = slot_send_seq[s] + 32'd1;
                            slot_state[s]    = tcse_pkg::ST_FIN_WAIT2;
                        end else if (slot_state[s] == tcse_pkg::ST_FIN_WAIT1) begin
                            o = with_reply(o, tcse_pkg::FLAG_ACK, slot_send_seq[s],
                                           slot_recv_ack[s]);
                            o.release_queue = 1'b1;
                            slot_state[s]   = tcse_pkg::ST_CLOSED;
                        end
                    end
                end
            end
            tcse_pkg::FLAG_RST, tcse_pkg::FLAG_RST_ACK: begin
                if (hit) begin
                    slot_state[s]   = tcse_pkg::ST_CLOSED;
                    o.release_queue = 1'b1;
                end
            end
            default: ;
        endcase

        if (hit)
            o.slot_state_out = slot_state[s];
        return o;
    endfunction

    function automatic tcse_pkg::tcse_req_t segment_request(
        input logic [7:0]  flags, input logic [31:0] seq, input logic [31:0] ack,
        input logic [15:0] len, input logic [3:0] hw, input logic cks, input logic hit,
        input logic [3:0]  slot, input logic [31:0] iss, input logic room);
        tcse_pkg::tcse_req_t r;
        r                  = '0;
        r.opcode           = tcse_pkg::OP_SEGMENT;
        r.tcp_flags        = flags;
        r.seq_num          = seq;
        r.ack_num          = ack;
        r.segment_len      = len;
        r.header_words     = hw;
        r.checksum_ok      = cks;
        r.lookup_hit       = hit;
        r.slot_index       = slot;
        r.initial_send_seq = iss;
        r.buffer_room      = room;
        return r;
    endfunction

    function automatic tcse_pkg::tcse_req_t host_write_request(input logic [3:0] slot,
                                                               input logic [2:0] st,
                                                               input logic [31:0] seq);
        tcse_pkg::tcse_req_t r;
        r            = '0;
        r.opcode     = tcse_pkg::OP_HOST_WRITE;
        r.slot_index = slot;
        r.host_state = st;
        r.seq_num    = seq;
        return r;
    endfunction

    function automatic tcse_pkg::tcse_rsp_t typed_result(input logic [7:0] flags,
                                                         input logic [31:0] seq,
                                                         input logic [31:0] ack,
                                                         input logic [15:0] payload,
                                                         input tcse_pkg::conn_state_t st);
        tcse_pkg::tcse_rsp_t o;
        o                = '0;
        o.reply_valid    = (flags != tcse_pkg::FLAG_NONE);
        o.reply_flags    = flags;
        o.reply_seq      = seq;
        o.reply_ack      = ack;
        o.payload_bytes  = payload;
        o.slot_state_out = st;
        return o;
    endfunction

    function automatic void add_row(input tcse_pkg::tcse_req_t req, input bit seq_live,
                                    input bit ack_live, input bit typed,
                                    input tcse_pkg::tcse_rsp_t rsp);
        stim_row_t row;
        row.req      = req;
        row.seq_live = seq_live;
        row.ack_live = ack_live;
        row.typed    = typed;
        row.rsp      = rsp;
        stimulus_rows.push_back(row);
    endfunction

    // Mostly well-formed segments on a few busy slots, plus host writes and noise
    function automatic tcse_pkg::tcse_req_t random_request();
        tcse_pkg::tcse_req_t r;
        int                  kind;
        int                  pick;
        int                  s;
        logic [15:0]         body;
        kind = $urandom_range(0, 99);
        s    = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, SLOTS - 1);

        r.opcode           = tcse_pkg::OP_SEGMENT;
        r.tcp_flags        = 8'($urandom);
        r.seq_num          = $urandom;
        r.ack_num          = $urandom;
        r.segment_len      = 16'($urandom);
        r.header_words     = 4'($urandom);
        r.checksum_ok      = 1'($urandom);
        r.lookup_hit       = 1'($urandom);
        r.slot_index       = 4'(s);
        r.initial_send_seq = $urandom;
        r.buffer_room      = 1'($urandom);
        r.host_state       = 3'($urandom);

        if (kind < 8) begin
            r.opcode     = 1'($urandom);
            r.slot_index = 4'($urandom);
            return r;
        end
        if (kind < 16) begin
            r.opcode = tcse_pkg::OP_HOST_WRITE;
            return r;
        end

        pick = $urandom_range(0, 99);
        if (pick < 14)      r.tcp_flags = tcse_pkg::FLAG_SYN;
        else if (pick < 28) r.tcp_flags = tcse_pkg::FLAG_SYN_ACK;
        else if (pick < 44) r.tcp_flags = tcse_pkg::FLAG_ACK;
        else if (pick < 56) r.tcp_flags = tcse_pkg::FLAG_PSH_ACK;
        else if (pick < 64) r.tcp_flags = tcse_pkg::FLAG_CWR_PSH_ACK;
        else if (pick < 73) r.tcp_flags = tcse_pkg::FLAG_FIN;
        else if (pick < 83) r.tcp_flags = tcse_pkg::FLAG_FIN_ACK;
        else if (pick < 88) r.tcp_flags = tcse_pkg::FLAG_RST;
        else if (pick < 93) r.tcp_flags = tcse_pkg::FLAG_RST_ACK;

        r.checksum_ok = ($urandom_range(0, 19) != 0);
        r.lookup_hit  = ($urandom_range(0, 9) != 0);
        r.buffer_room = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 4) != 0) r.seq_num = slot_recv_ack[s];
        if ($urandom_range(0, 4) != 0) r.ack_num = slot_send_seq[s];

        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            r.segment_len = 16'($urandom_range(0, 19));
        end else if (pick < 13) begin
            r.segment_len = 16'($urandom_range(20, 70));
        end else begin
            r.header_words = 4'($urandom_range(5, 15));
            if (pick < 40)      body = 16'd0;
            else if (pick < 92) body = 16'($urandom_range(1, 100));
            else                body = 16'($urandom_range(0, 65535 - 60));
            r.segment_len = {10'd0, r.header_words, 2'b00} + body;
        end
        return r;
    endfunction

    // Hold the sender between bursts
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
    endtask

    // Present one request, wait for the handshake, record its outcome
    task automatic offer_request(input tcse_pkg::tcse_req_t req, input bit use_typed,
                                 input tcse_pkg::tcse_rsp_t typed_rsp);
        tcse_pkg::tcse_rsp_t predicted;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = compute_segment_outcome(req);
        segment_outcomes.push_back(use_typed ? typed_rsp : predicted);
        @(negedge aclk);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (segment_outcomes.size() != 0);
    endtask

    // Receiver: one long hold-off, otherwise a changing stall pattern
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_left = 400;
                long_hold_done = 1'b1;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:   m_ready <= 1'b1;
                    RX_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: m_ready <= ((rx_phase % 5) != 0);
                    RX_SPARSE:   m_ready <= ($urandom_range(0, 9) < 3);
                    default:     m_ready <= 1'b1;
                endcase
            end
            rx_phase++;
            if (rx_phase == 64) begin
                rx_phase = 0;
                rx_mode  = rx_pattern_t'($urandom_range(0, 3));
            end
        end
    end

    // Compare each result with the oldest outcome on record
    always @(posedge aclk) begin : check_results
        tcse_pkg::tcse_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (segment_outcomes.size() == 0) begin
                report_mismatch("result with no request outstanding",
                                m_data.reply_seq, 32'd0);
            end else begin
                want = segment_outcomes.pop_front();
                check_field("reply_valid", 32'(m_data.reply_valid), 32'(want.reply_valid));
                check_field("reply_flags", 32'(m_data.reply_flags), 32'(want.reply_flags));
                check_field("reply_seq", m_data.reply_seq, want.reply_seq);
                check_field("reply_ack", m_data.reply_ack, want.reply_ack);
                check_field("expire_valid", 32'(m_data.expire_valid), 32'(want.expire_valid));
                check_field("expire_upto", m_data.expire_upto, want.expire_upto);
                check_field("release_queue", 32'(m_data.release_queue),
                            32'(want.release_queue));
                check_field("payload_accept", 32'(m_data.payload_accept),
                            32'(want.payload_accept));
                check_field("payload_bytes", 32'(m_data.payload_bytes),
                            32'(want.payload_bytes));
                check_field("slot_state_out", 32'(m_data.slot_state_out),
                            32'(want.slot_state_out));
            end
        end
    end

    // Main sequence
    initial begin
        stim_row_t           row;
        tcse_pkg::tcse_req_t req;
        int                  issued;

        for (int i = 0; i < SLOTS; i++) begin
            slot_state[i]    = tcse_pkg::ST_CLOSED;
            slot_send_seq[i] = 32'd0;
            slot_recv_ack[i] = 32'd0;
        end

        // Rejected, miss and boundary cases with results typed in
        add_row(segment_request(tcse_pkg::FLAG_SYN, 32'h1, 32'h2, 16'd19, 4'd4, 1'b1,
                                1'b1, 4'd0, 32'h5, 1'b1), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_SYN, 32'h1, 32'h2, 16'd20, 4'd5, 1'b0,
                                1'b1, 4'd0, 32'h5, 1'b1), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_SYN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd20,
                                4'd5, 1'b1, 1'b0, 4'd15, 32'd0, 1'b0), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_RST_ACK, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_RST, 32'h0, 32'h0, 16'hFFFF, 4'd0, 1'b1,
                                1'b0, 4'd7, 32'd0, 1'b0), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'hFFFF,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd20, 4'd15, 1'b1,
                                1'b1, 4'd15, 32'hFFFF_FFFF, 1'b1), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_ACK, 32'd1234, 32'd5678, 16'd40, 4'd5,
                                1'b1, 1'b0, 4'd0, 32'd0, 1'b1), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_RST_ACK, 32'd5678, 32'd1234, 16'd20,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_SYN, 32'hFFFF_FFFF, 32'd0, 16'd20, 4'd5,
                                1'b1, 1'b1, 4'd0, 32'hFFFF_FFFF, 1'b1), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_SYN_ACK, 32'hFFFF_FFFF, 32'd0, 16'd0,
                             tcse_pkg::ST_SYN_RCVD));

        // Slot 0 through handshake, data, close
        add_row(segment_request(tcse_pkg::FLAG_ACK, 32'd0, 32'd0, 16'd20, 4'd5, 1'b1,
                                1'b1, 4'd0, 32'd0, 1'b1), 1, 1, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_PSH_ACK, 32'd0, 32'd0, 16'd120, 4'd5,
                                1'b1, 1'b1, 4'd0, 32'd0, 1'b1), 1, 1, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_CWR_PSH_ACK, 32'd0, 32'd0, 16'd120, 4'd5,
                                1'b1, 1'b1, 4'd0, 32'd0, 1'b0), 1, 1, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_ACK, 32'hDEAD_BEEF, 32'd0, 16'd60, 4'd5,
                                1'b1, 1'b1, 4'd0, 32'd0, 1'b1), 0, 1, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_FIN_ACK, 32'd0, 32'd0, 16'd20, 4'd5,
                                1'b1, 1'b1, 4'd0, 32'd0, 1'b1), 1, 1, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_ACK, 32'd0, 32'd0, 16'd20, 4'd5, 1'b1,
                                1'b1, 4'd0, 32'd0, 1'b1), 1, 1, 0, '0);

        // Slot 1 as an active opener
        add_row(host_write_request(4'd1, tcse_pkg::ST_SYN_SENT, 32'h8000_0000), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_SYN_SENT));
        add_row(segment_request(tcse_pkg::FLAG_SYN_ACK, 32'h1234_5678, 32'd0, 16'd20,
                                4'd5, 1'b1, 1'b1, 4'd1, 32'd0, 1'b1), 0, 0, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_SYN_ACK, 32'h1234_5678, 32'd0, 16'd20,
                                4'd5, 1'b1, 1'b1, 4'd1, 32'd0, 1'b1), 0, 1, 0, '0);

        // Slot 2: out-of-range state written, then fin wait 1 closed by FIN
        add_row(host_write_request(4'd2, 3'd7, 32'hFFFF_FFFF), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(host_write_request(4'd2, tcse_pkg::ST_FIN_WAIT1, 32'd0), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_FIN_WAIT1));
        add_row(segment_request(tcse_pkg::FLAG_FIN, 32'd77, 32'd0, 16'd20, 4'd5, 1'b1,
                                1'b1, 4'd2, 32'd0, 1'b1), 0, 1, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_FIN, 32'd0, 32'd1, 16'd20, 4'd5, 1'b1,
                                1'b1, 4'd1, 32'd0, 1'b1), 0, 0, 0, '0);
        add_row(segment_request(tcse_pkg::FLAG_SYN_ACK, 32'd0, 32'd0, 16'd20, 4'd5, 1'b1,
                                1'b0, 4'd1, 32'd0, 1'b1), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_RST_ACK, 32'd1, 32'd1, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_FIN, 32'd10, 32'd20, 16'd20, 4'd5, 1'b1,
                                1'b0, 4'd1, 32'd0, 1'b1), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_RST_ACK, 32'd21, 32'd11, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_RST_ACK, 32'd0, 32'd0, 16'd20, 4'd5, 1'b1,
                                1'b1, 4'd1, 32'd0, 1'b1), 0, 0, 0, '0);
        add_row(host_write_request(4'd3, 3'd6, 32'h5555_AAAA), 0, 0, 1,
                typed_result(tcse_pkg::FLAG_NONE, 32'd0, 32'd0, 16'd0,
                             tcse_pkg::ST_CLOSED));
        add_row(segment_request(tcse_pkg::FLAG_FIN, 32'd0, 32'd0, 16'd20, 4'd5, 1'b1,
                                1'b1, 4'd3, 32'd0, 1'b1), 1, 1, 0, '0);

        // Synchronous reset, released on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table
        foreach (stimulus_rows[i]) begin
            row = stimulus_rows[i];
            if (row.seq_live) row.req.seq_num = slot_recv_ack[row.req.slot_index];
            if (row.ack_live) row.req.ack_num = slot_send_seq[row.req.slot_index];
            pace_sender();
            offer_request(row.req, row.typed, row.rsp);
        end

        // Random traffic; pause once mid-way until the block is empty
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            if (issued == 600)
                wait_for_drain();
            req = random_request();
            pace_sender();
            offer_request(req, 1'b0, '0);
            issued++;
        end

        // Drain and let the pipeline settle
        s_valid <= 1'b0;
        while (segment_outcomes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0 && segment_outcomes.size() == 0) begin
            $display("** tcp_connection_state_engine: PASSED **");
        end else begin
            $display("** tcp_connection_state_engine: FAILED **");
        end
        $finish;
    end

endmodule
